// ===== rtl/spq_pkg.sv =====
// spq_pkg: shared types and constants for the stable priority queue.
// No dependencies; imported by every module of the block but spq_ram.
package spq_pkg;

    localparam int LEVEL_W      = 3;
    localparam int NUM_LEVELS   = 1 << LEVEL_W;
    localparam int DEF_CAPACITY = 32;
    localparam int DEF_TAG_BITS = 16;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_POP    = 1'b1
    } cmd_t;

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic do_insert;
        logic do_drop;
        logic do_pop_start;
        logic do_pop_empty;
        logic load_pop;
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic full;
        logic empty;
        logic out_busy;
    } ctrl_status_t;

endpackage

// ===== rtl/spq_ram.sv =====
// spq_ram: generic single-port RAM with registered read.
// No dependencies.
module spq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== rtl/spq_ctrl.sv =====
// spq_ctrl: request sequencing for the stable priority queue.
// Depends on spq_pkg; drives the datapath through ctrl_cmd_t.
module spq_ctrl
    import spq_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    input  logic         s_command,
    input  ctrl_status_t status,
    output logic         s_ready,
    output ctrl_cmd_t    cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                // nothing is taken while reset is held
                s_ready = aresetn && !status.out_busy;
                if (s_valid && s_ready) begin
                    if (s_command == CMD_INSERT) begin
                        cmd.do_insert = !status.full;
                        cmd.do_drop   = status.full;
                    end else if (status.empty) begin
                        cmd.do_pop_empty = 1'b1;
                    end else begin
                        cmd.do_pop_start = 1'b1;
                        state_next       = ST_READ;
                    end
                end
            end
            ST_READ: begin
                // store read data lands this cycle
                cmd.load_pop = 1'b1;
                state_next   = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/spq_datapath.sv =====
// spq_datapath: per-level circular queues in one RAM, counters, result register.
// Depends on spq_pkg and spq_ram; commanded by spq_ctrl.
module spq_datapath
    import spq_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY,
    parameter int TAG_BITS = DEF_TAG_BITS,
    localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [LEVEL_W-1:0]  s_urgency,
    input  logic [TAG_BITS-1:0] s_entry_tag,
    input  logic                m_ready,
    input  ctrl_cmd_t           cmd,
    output ctrl_status_t        status,
    output logic                m_valid,
    output logic                m_pop_valid,
    output logic [LEVEL_W-1:0]  m_pop_urgency,
    output logic [TAG_BITS-1:0] m_pop_tag,
    output logic                m_insert_dropped,
    output logic [CNT_W-1:0]    m_waiting_count
);

    localparam int PTR_W  = $clog2(CAPACITY);
    localparam int ADDR_W = LEVEL_W + PTR_W;
    // address is {level, pointer}, so each level owns a power-of-two stride
    localparam int DEPTH  = NUM_LEVELS << PTR_W;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(CAPACITY - 1)) begin
            r = '0;
        end else begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    logic [PTR_W-1:0]    head_reg    [NUM_LEVELS];
    logic [PTR_W-1:0]    tail_reg    [NUM_LEVELS];
    logic [CNT_W-1:0]    lvl_cnt_reg [NUM_LEVELS];
    logic [CNT_W-1:0]    total_reg, total_next;
    logic [LEVEL_W-1:0]  pop_lvl_reg;
    logic [NUM_LEVELS-1:0] nonempty;
    logic [LEVEL_W-1:0]  pop_lvl;
    logic [ADDR_W-1:0]   ram_addr;
    logic [TAG_BITS-1:0] ram_rdata;

    logic                m_valid_reg;
    logic                pop_valid_reg;
    logic [LEVEL_W-1:0]  pop_urgency_reg;
    logic [TAG_BITS-1:0] pop_tag_reg;
    logic                dropped_reg;
    logic [CNT_W-1:0]    count_reg;

    // most urgent non-empty level: lowest index wins
    always_comb begin
        pop_lvl = '0;
        for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
            nonempty[i] = (lvl_cnt_reg[i] != '0);
            if (nonempty[i]) begin
                pop_lvl = LEVEL_W'(i);
            end
        end
    end

    assign ram_addr = cmd.do_insert ? {s_urgency, tail_reg[s_urgency]}
                                    : {pop_lvl, head_reg[pop_lvl]};

    spq_ram #(
        .WIDTH (TAG_BITS),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (cmd.do_insert),
        .addr  (ram_addr),
        .wdata (s_entry_tag),
        .rdata (ram_rdata)
    );

    always_comb begin
        total_next = total_reg;
        if (cmd.do_insert) begin
            total_next = total_reg + 1'b1;
        end else if (cmd.do_pop_start) begin
            total_next = total_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg <= '0;
            for (int i = 0; i < NUM_LEVELS; i++) begin
                head_reg[i]    <= '0;
                tail_reg[i]    <= '0;
                lvl_cnt_reg[i] <= '0;
            end
        end else begin
            total_reg <= total_next;
            if (cmd.do_insert) begin
                tail_reg[s_urgency]    <= ptr_inc(tail_reg[s_urgency]);
                lvl_cnt_reg[s_urgency] <= lvl_cnt_reg[s_urgency] + 1'b1;
            end
            if (cmd.do_pop_start) begin
                head_reg[pop_lvl]    <= ptr_inc(head_reg[pop_lvl]);
                lvl_cnt_reg[pop_lvl] <= lvl_cnt_reg[pop_lvl] - 1'b1;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.do_insert || cmd.do_drop || cmd.do_pop_empty || cmd.load_pop) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.do_pop_start) begin
            pop_lvl_reg <= pop_lvl;
        end
        if (cmd.do_insert || cmd.do_drop || cmd.do_pop_empty) begin
            pop_valid_reg   <= 1'b0;
            pop_urgency_reg <= '0;
            pop_tag_reg     <= '0;
            dropped_reg     <= cmd.do_drop;
            count_reg       <= total_next;
        end else if (cmd.load_pop) begin
            pop_valid_reg   <= 1'b1;
            pop_urgency_reg <= pop_lvl_reg;
            pop_tag_reg     <= ram_rdata;
            dropped_reg     <= 1'b0;
            count_reg       <= total_reg;
        end
    end

    assign status.full     = (total_reg == CNT_W'(CAPACITY));
    assign status.empty    = (total_reg == '0);
    assign status.out_busy = m_valid_reg && !m_ready;

    assign m_valid          = m_valid_reg;
    assign m_pop_valid      = pop_valid_reg;
    assign m_pop_urgency    = pop_urgency_reg;
    assign m_pop_tag        = pop_tag_reg;
    assign m_insert_dropped = dropped_reg;
    assign m_waiting_count  = count_reg;

endmodule

// ===== rtl/stable_priority_queue.sv =====
// Stable priority queue, top level.
// Depends on spq_pkg, spq_ctrl, spq_datapath (and spq_ram below it).
//
// Usage:
//   Input channel (s_valid/s_ready): one request per handshake. s_command
//   selects insert (store s_entry_tag at level s_urgency) or pop (return
//   the front entry). Levels are the raw 3-bit urgency; lower is served
//   first and entries of one level leave in arrival order.
//   Result channel (m_valid/m_ready): exactly one result per request,
//   carrying the popped entry (or zeros), the drop flag for an insert
//   into a full store, and the number of entries waiting afterwards.
// Request handling:
//   Insert, dropped insert and pop from empty: result registered in the cycle
//   after acceptance; a new request can be taken every cycle while no result
//   is held. Pop returning an entry: the shared tag RAM read is registered,
//   then the controller's read state loads it into the result register and takes no new request.
// Storage: one circular queue per level inside one RAM of 8 x CAPACITY
//   tags (CAPACITY rounded up to a power of two); a shared total caps it.
// Reset: s_ready is low; counters and pointers clear at once; the RAM is
//   not cleared and no clearing pass is needed, as only written slots are read.
// Stall: while a result waits with m_ready low, s_ready stays low; a new
//   request is taken in the cycle the held result is taken.
module stable_priority_queue
    import spq_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY,
    parameter int TAG_BITS = DEF_TAG_BITS,
    localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_command,
    input  logic [LEVEL_W-1:0]  s_urgency,
    input  logic [TAG_BITS-1:0] s_entry_tag,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_pop_valid,
    output logic [LEVEL_W-1:0]  m_pop_urgency,
    output logic [TAG_BITS-1:0] m_pop_tag,
    output logic                m_insert_dropped,
    output logic [CNT_W-1:0]    m_waiting_count
);

    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    // sequencing: accept, issue store access, hold for the read when popping
    spq_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_command (s_command),
        .status    (status),
        .s_ready   (s_ready),
        .cmd       (cmd)
    );

    // per-level queues, counts and the result register
    spq_datapath #(
        .CAPACITY (CAPACITY),
        .TAG_BITS (TAG_BITS)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_urgency        (s_urgency),
        .s_entry_tag      (s_entry_tag),
        .m_ready          (m_ready),
        .cmd              (cmd),
        .status           (status),
        .m_valid          (m_valid),
        .m_pop_valid      (m_pop_valid),
        .m_pop_urgency    (m_pop_urgency),
        .m_pop_tag        (m_pop_tag),
        .m_insert_dropped (m_insert_dropped),
        .m_waiting_count  (m_waiting_count)
    );

`ifndef SYNTHESIS
    // count can never pass the capacity
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_waiting_count <= CNT_W'(CAPACITY)))
        else $error("waiting count above capacity");

    // a drop only happens with the store full
    a_drop_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_insert_dropped) |->
            (m_waiting_count == CNT_W'(CAPACITY) && !m_pop_valid))
        else $error("drop reported with room left");

    // insert results are registered in the cycle after acceptance
    a_insert_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_command == CMD_INSERT) |=> (m_valid && !m_pop_valid))
        else $error("insert result missing");

    // no entry returned means zero payload
    a_empty_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_pop_valid) |-> (m_pop_tag == '0 && m_pop_urgency == '0))
        else $error("stale payload on result without entry");
`endif

endmodule
